FILE: hdl/heater_temperature_pid_power_top_defines.svh
// Assertion macros for the heater temperature PID power block.
`ifndef HEATER_TEMPERATURE_PID_POWER_TOP_DEFINES_SVH
`define HEATER_TEMPERATURE_PID_POWER_TOP_DEFINES_SVH

// check cons in the same cycle as ante, on clk, off while arst_n is low
`define HTP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("htp assertion failed");

// check cons in the cycle after ante, on clk, off while arst_n is low
`define HTP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("htp assertion failed");

`endif

FILE: hdl/htp_pkg.sv
// Package with widths, limits and register codes of the heater PID power block.
`default_nettype none
package htp_pkg;
	localparam int TEMP_W    = 10;
	localparam int RES_W     = 16;
	localparam int GAIN_W    = 16;
	localparam int DRIVE_W   = 16;
	localparam int WORD_W    = 32;
	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 32;
	localparam int QUOT_W    = 27;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [2:0]        reg_idx_t;

	localparam reg_idx_t REG_TARGET_TEMP = 3'd0;
	localparam reg_idx_t REG_GAIN_P      = 3'd1;
	localparam reg_idx_t REG_GAIN_I      = 3'd2;
	localparam reg_idx_t REG_GAIN_D      = 3'd3;
	localparam reg_idx_t REG_INIT_WATTS  = 3'd4;

	localparam logic [RES_W-1:0]   LIMIT_RES_MOHM = 16'd1000;
	localparam logic signed [31:0] FALLBACK_MW    = 32'sd1000;
	localparam logic signed [31:0] WILD_MW        = 32'sd100000;
	localparam logic signed [31:0] CAP_MW         = 32'sd60000;

	// magnitude / 100 == (magnitude * RECIP_100) >> RECIP_SHIFT for 32-bit magnitudes
	localparam logic [31:0] RECIP_100   = 32'h51EB851F;
	localparam int          RECIP_SHIFT = 37;
endpackage
`default_nettype wire

FILE: hdl/htp_meas_if.sv
// Channel interface for the measurement words entering the block.
`default_nettype none
interface htp_meas_if;
	logic                        valid;
	logic                        ready;
	logic                        start_req;
	logic [htp_pkg::TEMP_W-1:0]  temperature;
	logic [htp_pkg::RES_W-1:0]   resistance;

	modport source(output valid, start_req, temperature, resistance, input ready);
	modport sink(input valid, start_req, temperature, resistance, output ready);
endinterface
`default_nettype wire

FILE: hdl/htp_drive_if.sv
// Channel interface for the power words leaving the block.
`default_nettype none
interface htp_drive_if;
	logic                         valid;
	logic                         ready;
	logic [htp_pkg::DRIVE_W-1:0]  drive_watts;
	logic signed [htp_pkg::WORD_W-1:0] next_watts;

	modport source(output valid, drive_watts, next_watts, input ready);
	modport sink(input valid, drive_watts, next_watts, output ready);
endinterface
`default_nettype wire

FILE: hdl/heater_temperature_pid_power_top.sv
// An accepted measurement word passes through the stage 1 to 4 registers into the output register.
// Throughput: one word per cycle unless the output holds a word that drive.ready does not take; the three gain
// multiplies and the divide-by-100 reciprocal multiplies run in their own pipeline stages, and only the clamp and add
// close the power loop. Reset (arst_n low, asynchronous): registers, power, integrator and last error
// go to zero, all stages empty.
`default_nettype none
`include "heater_temperature_pid_power_top_defines.svh"
module heater_temperature_pid_power_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [htp_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [htp_pkg::PDATA_W-1:0]   pwdata,
	output      logic [htp_pkg::PDATA_W-1:0]   prdata,
	output      logic                          pready,
	htp_meas_if.sink                           meas,
	htp_drive_if.source                        drive
);
	// configuration registers
	logic [htp_pkg::TEMP_W-1:0]  target_temp_q;
	logic [htp_pkg::GAIN_W-1:0]  gain_p_q;
	logic [htp_pkg::GAIN_W-1:0]  gain_i_q;
	logic [htp_pkg::GAIN_W-1:0]  gain_d_q;
	logic [htp_pkg::DRIVE_W-1:0] init_watts_q;
	htp_pkg::reg_idx_t           reg_idx;
	logic                        cfg_wr;

	// loop state
	htp_pkg::word_t power_q;
	htp_pkg::word_t esum_q;
	htp_pkg::word_t last_err_q;

	// stage 1: error terms
	logic                       v_s1;
	logic                       start_s1;
	logic [htp_pkg::RES_W-1:0]  res_s1;
	htp_pkg::word_t             err_s1;
	htp_pkg::word_t             esum_s1;
	htp_pkg::word_t             diff_s1;

	// stage 2: wrapped gain products
	logic                       v_s2;
	logic                       start_s2;
	logic [htp_pkg::RES_W-1:0]  res_s2;
	htp_pkg::word_t             prod_p_s2;
	htp_pkg::word_t             prod_i_s2;
	htp_pkg::word_t             prod_d_s2;

	// stage 3: quotient magnitudes and signs
	logic                       v_s3;
	logic                       start_s3;
	logic [htp_pkg::RES_W-1:0]  res_s3;
	logic [htp_pkg::QUOT_W-1:0] quot_p_s3;
	logic [htp_pkg::QUOT_W-1:0] quot_i_s3;
	logic [htp_pkg::QUOT_W-1:0] quot_d_s3;
	logic                       neg_p_s3;
	logic                       neg_i_s3;
	logic                       neg_d_s3;

	// stage 4: PID output
	logic                       v_s4;
	logic                       start_s4;
	logic [htp_pkg::RES_W-1:0]  res_s4;
	htp_pkg::word_t             pid_s4;

	// output register
	logic                        out_v_q;
	logic [htp_pkg::DRIVE_W-1:0] drive_q;
	htp_pkg::word_t              next_q;

	logic adv_o, adv4, adv3, adv2, adv1;
	logic accept;

	htp_pkg::word_t err_c, esum_c, diff_c;
	htp_pkg::word_t prod_p_c, prod_i_c, prod_d_c;
	htp_pkg::word_t mag_p_c, mag_i_c, mag_d_c;
	logic [63:0]    full_p_c, full_i_c, full_d_c;
	htp_pkg::word_t term_p_c, term_i_c, term_d_c;
	htp_pkg::word_t pw_c, pw_res_c, pw_wild_c, pw_cap_c, next_c;

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[htp_pkg::PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_temp_q <= '0;
			gain_p_q      <= '0;
			gain_i_q      <= '0;
			gain_d_q      <= '0;
			init_watts_q  <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				htp_pkg::REG_TARGET_TEMP: target_temp_q <= pwdata[htp_pkg::TEMP_W-1:0];
				htp_pkg::REG_GAIN_P:      gain_p_q      <= pwdata[htp_pkg::GAIN_W-1:0];
				htp_pkg::REG_GAIN_I:      gain_i_q      <= pwdata[htp_pkg::GAIN_W-1:0];
				htp_pkg::REG_GAIN_D:      gain_d_q      <= pwdata[htp_pkg::GAIN_W-1:0];
				htp_pkg::REG_INIT_WATTS:  init_watts_q  <= pwdata[htp_pkg::DRIVE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			htp_pkg::REG_TARGET_TEMP: prdata = {22'b0, target_temp_q};
			htp_pkg::REG_GAIN_P:      prdata = {16'b0, gain_p_q};
			htp_pkg::REG_GAIN_I:      prdata = {16'b0, gain_i_q};
			htp_pkg::REG_GAIN_D:      prdata = {16'b0, gain_d_q};
			htp_pkg::REG_INIT_WATTS:  prdata = {16'b0, init_watts_q};
			default:                  prdata = '0;
		endcase
	end

	// stall chain: a stage advances when it is empty or the next one advances
	assign adv_o      = !out_v_q || drive.ready;
	assign adv4       = !v_s4 || adv_o;
	assign adv3       = !v_s3 || adv4;
	assign adv2       = !v_s2 || adv3;
	assign adv1       = !v_s1 || adv2;
	assign meas.ready = adv1;
	assign accept     = meas.valid && adv1;

	// error, integrator and derivative on accept
	assign err_c  = {22'b0, target_temp_q} - {22'b0, meas.temperature};
	assign esum_c = (meas.start_req ? '0 : esum_q) + err_c;
	assign diff_c = last_err_q - err_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esum_q     <= '0;
			last_err_q <= '0;
		end else if (accept) begin
			esum_q     <= esum_c;
			last_err_q <= err_c;
		end
	end

	// products wrap to 32 bits
	assign prod_p_c = {16'b0, gain_p_q} * err_s1;
	assign prod_i_c = {16'b0, gain_i_q} * esum_s1;
	assign prod_d_c = {16'b0, gain_d_q} * diff_s1;

	// truncating divide by 100 on the magnitude
	assign mag_p_c  = prod_p_s2[31] ? -prod_p_s2 : prod_p_s2;
	assign mag_i_c  = prod_i_s2[31] ? -prod_i_s2 : prod_i_s2;
	assign mag_d_c  = prod_d_s2[31] ? -prod_d_s2 : prod_d_s2;
	assign full_p_c = {32'b0, mag_p_c} * {32'b0, htp_pkg::RECIP_100};
	assign full_i_c = {32'b0, mag_i_c} * {32'b0, htp_pkg::RECIP_100};
	assign full_d_c = {32'b0, mag_d_c} * {32'b0, htp_pkg::RECIP_100};

	// restore signs and sum
	assign term_p_c = neg_p_s3 ? -{5'b0, quot_p_s3} : {5'b0, quot_p_s3};
	assign term_i_c = neg_i_s3 ? -{5'b0, quot_i_s3} : {5'b0, quot_i_s3};
	assign term_d_c = neg_d_s3 ? -{5'b0, quot_d_s3} : {5'b0, quot_d_s3};

	// clamp the stored power, then add the PID output
	assign pw_c      = start_s4 ? {16'b0, init_watts_q} : power_q;
	assign pw_res_c  = (res_s4 > htp_pkg::LIMIT_RES_MOHM) ? '0 : pw_c;
	assign pw_wild_c = (pw_res_c[31] || ($signed(pw_res_c) > htp_pkg::WILD_MW))
		? htp_pkg::FALLBACK_MW : pw_res_c;
	assign pw_cap_c  = ($signed(pw_wild_c) > htp_pkg::CAP_MW) ? htp_pkg::CAP_MW : pw_wild_c;
	assign next_c    = pw_cap_c + pid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			out_v_q <= 1'b0;
			power_q <= '0;
		end else begin
			if (adv1) begin
				v_s1 <= meas.valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
			if (adv4) begin
				v_s4 <= v_s3;
			end
			if (adv_o) begin
				out_v_q <= v_s4;
				if (v_s4) begin
					power_q <= next_c;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			start_s1 <= meas.start_req;
			res_s1   <= meas.resistance;
			err_s1   <= err_c;
			esum_s1  <= esum_c;
			diff_s1  <= diff_c;
		end
		if (adv2) begin
			start_s2  <= start_s1;
			res_s2    <= res_s1;
			prod_p_s2 <= prod_p_c;
			prod_i_s2 <= prod_i_c;
			prod_d_s2 <= prod_d_c;
		end
		if (adv3) begin
			start_s3  <= start_s2;
			res_s3    <= res_s2;
			quot_p_s3 <= full_p_c[63:htp_pkg::RECIP_SHIFT];
			quot_i_s3 <= full_i_c[63:htp_pkg::RECIP_SHIFT];
			quot_d_s3 <= full_d_c[63:htp_pkg::RECIP_SHIFT];
			neg_p_s3  <= prod_p_s2[31];
			neg_i_s3  <= prod_i_s2[31];
			neg_d_s3  <= prod_d_s2[31];
		end
		if (adv4) begin
			start_s4 <= start_s3;
			res_s4   <= res_s3;
			pid_s4   <= term_p_c + term_i_c + term_d_c;
		end
		if (adv_o) begin
			drive_q <= pw_cap_c[htp_pkg::DRIVE_W-1:0];
			next_q  <= next_c;
		end
	end

	assign drive.valid       = out_v_q;
	assign drive.drive_watts = drive_q;
	assign drive.next_watts  = next_q;

	`HTP_ASSERT_NOW(a_drive_capped, drive.valid,
		{16'b0, drive.drive_watts} <= htp_pkg::CAP_MW)
	`HTP_ASSERT_NOW(a_ready_when_out_free, !out_v_q, meas.ready)
	`HTP_ASSERT_NEXT(a_start_clears_sum, meas.valid && meas.ready && meas.start_req,
		esum_q == err_s1)
endmodule
`default_nettype wire

FILE: sim/tb_heater_temperature_pid_power_top.sv
// Testbench for the heater PID power loop, checked against a local loop model.
module tb_heater_temperature_pid_power_top;
	import htp_pkg::*;

	localparam int GAIN_SCALE   = 100;
	localparam int DRAIN_CYCLES = 12;
	localparam int LONG_HOLD    = 80;
	localparam int N_PHASES     = 8;
	localparam int PHASE_ITEMS  = 67;

	typedef struct packed {
		logic              start_req;
		logic [TEMP_W-1:0] temperature;
		logic [RES_W-1:0]  resistance;
	} meas_word_t;

	typedef struct packed {
		logic [DRIVE_W-1:0] drive_watts;
		logic [WORD_W-1:0]  next_watts;
	} power_word_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	htp_meas_if  meas();
	htp_drive_if drive();

	heater_temperature_pid_power_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.meas    (meas),
		.drive   (drive)
	);

	meas_word_t  pending_meas_q[$];
	power_word_t expected_power_q[$];

	logic [TEMP_W-1:0] cfg_target = '0;
	logic [GAIN_W-1:0] cfg_kp     = '0;
	logic [GAIN_W-1:0] cfg_ki     = '0;
	logic [GAIN_W-1:0] cfg_kd     = '0;
	logic [15:0]       cfg_init   = '0;

	logic [WORD_W-1:0] loop_power = '0;
	logic [WORD_W-1:0] loop_integ = '0;
	logic [WORD_W-1:0] loop_prev  = '0;

	int mismatch_count = 0;
	int words_seen     = 0;

	bit src_bursty   = 1'b0;
	int burst_left   = 0;
	int gap_left     = 0;
	int sink_mode    = 0;
	int sink_phase   = 0;
	int hold_left    = 0;
	int hold_seq     = 0;
	int hold_seen    = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [WORD_W-1:0] gain_term(input logic [GAIN_W-1:0] gain,
			input logic [WORD_W-1:0] value);
		logic [WORD_W-1:0] prod;
		int q;
		prod = {{(WORD_W-GAIN_W){1'b0}}, gain} * value;
		q = $signed(prod) / GAIN_SCALE;
		return q;
	endfunction

	function automatic void power_step(input meas_word_t w, output power_word_t p);
		logic [WORD_W-1:0] err;
		logic [WORD_W-1:0] diff;
		if (w.start_req) begin
			loop_integ = '0;
			loop_power = {16'd0, cfg_init};
		end
		if (w.resistance > LIMIT_RES_MOHM)
			loop_power = '0;
		if ($signed(loop_power) < 0 || $signed(loop_power) > WILD_MW)
			loop_power = FALLBACK_MW;
		if ($signed(loop_power) > CAP_MW)
			loop_power = CAP_MW;
		p.drive_watts = loop_power[DRIVE_W-1:0];
		err = {{(WORD_W-TEMP_W){1'b0}}, cfg_target} - {{(WORD_W-TEMP_W){1'b0}}, w.temperature};
		loop_integ = loop_integ + err;
		diff = loop_prev - err;
		loop_prev = err;
		loop_power = loop_power + gain_term(cfg_kp, err) + gain_term(cfg_ki, loop_integ)
			+ gain_term(cfg_kd, diff);
		p.next_watts = loop_power;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t word %0d: %s got 0x%h want 0x%h", $time, words_seen, what, got, want);
		mismatch_count++;
	endtask

	// sender: bursts with gaps when src_bursty is set, holds the word until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meas.valid       <= 1'b0;
			meas.start_req   <= 1'b0;
			meas.temperature <= '0;
			meas.resistance  <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else if (!meas.valid || meas.ready) begin
			if (gap_left > 0) begin
				meas.valid <= 1'b0;
				gap_left--;
			end else if (pending_meas_q.size() > 0) begin
				meas_word_t w;
				w = pending_meas_q.pop_front();
				meas.valid       <= 1'b1;
				meas.start_req   <= w.start_req;
				meas.temperature <= w.temperature;
				meas.resistance  <= w.resistance;
				if (src_bursty) begin
					if (burst_left == 0)
						burst_left = $urandom_range(1, 12);
					burst_left--;
					if (burst_left == 0)
						gap_left = $urandom_range(1, 6);
				end
			end else begin
				meas.valid <= 1'b0;
			end
		end
	end

	// receiver: always ready, random stalls or a stall pattern by sink_mode, plus a long hold when hold_seq changes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive.ready <= 1'b0;
			hold_left  = 0;
			sink_phase = 0;
		end else begin
			if (hold_seen != hold_seq) begin
				hold_seen = hold_seq;
				hold_left = LONG_HOLD;
			end
			sink_phase = (sink_phase + 1) % 5;
			if (hold_left > 0) begin
				hold_left--;
				drive.ready <= 1'b0;
			end else begin
				case (sink_mode)
					0: drive.ready <= 1'b1;
					1: drive.ready <= ($urandom_range(0, 99) >= 35);
					default: drive.ready <= (sink_phase >= 2);
				endcase
			end
		end
	end

	always @(posedge clk) begin : monitor
		power_word_t p;
		power_word_t want;
		if (arst_n && meas.valid && meas.ready) begin
			power_step({meas.start_req, meas.temperature, meas.resistance}, p);
			expected_power_q.push_back(p);
		end
		if (arst_n && drive.valid && drive.ready) begin
			words_seen++;
			if (expected_power_q.size() == 0) begin
				report_mismatch("unexpected word", {16'd0, drive.drive_watts}, drive.next_watts);
			end else begin
				want = expected_power_q.pop_front();
				if (drive.drive_watts !== want.drive_watts)
					report_mismatch("drive_watts", {16'd0, drive.drive_watts},
						{16'd0, want.drive_watts});
				if (drive.next_watts !== want.next_watts)
					report_mismatch("next_watts", drive.next_watts, want.next_watts);
			end
		end
	end

	task automatic cfg_write(input reg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_TARGET_TEMP: cfg_target = val[TEMP_W-1:0];
			REG_GAIN_P:      cfg_kp     = val[GAIN_W-1:0];
			REG_GAIN_I:      cfg_ki     = val[GAIN_W-1:0];
			REG_GAIN_D:      cfg_kd     = val[GAIN_W-1:0];
			REG_INIT_WATTS:  cfg_init   = val[15:0];
			default: ;
		endcase
	endtask

	task automatic wait_idle;
		do @(negedge clk);
		while (pending_meas_q.size() != 0 || meas.valid || expected_power_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic push_meas(input logic s, input int temp, input int res);
		meas_word_t w;
		w.start_req   = s;
		w.temperature = TEMP_W'(temp);
		w.resistance  = RES_W'(res);
		pending_meas_q.push_back(w);
	endtask

	function automatic logic [31:0] with_junk(input logic [31:0] v, input int width);
		if ($urandom_range(0, 2) == 0)
			return v | ($urandom << width);
		return v;
	endfunction

	function automatic logic [31:0] pick_gain;
		case ($urandom_range(0, 4))
			0: return 32'd0;
			1: return 32'd65535;
			2: return $urandom_range(0, 300);
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	task automatic push_ticks(input int n, input bit fresh, input bit cold);
		int left;
		int near;
		meas_word_t w;
		left = fresh ? 0 : (cold ? n : $urandom_range(1, 40));
		for (int i = 0; i < n; i++) begin
			w.start_req = (left == 0) || (!cold && $urandom_range(0, 24) == 0);
			if (left == 0)
				left = cold ? n : $urandom_range(1, 40);
			left--;
			if (cold) begin
				w.temperature = TEMP_W'($urandom_range(0, 63));
			end else begin
				case ($urandom_range(0, 2))
					0: begin
						near = int'(cfg_target) + int'($urandom_range(0, 40)) - 20;
						w.temperature = TEMP_W'((near < 0) ? 0 : (near > 1023) ? 1023 : near);
					end
					1: w.temperature = TEMP_W'($urandom_range(0, 63));
					default: w.temperature = TEMP_W'($urandom_range(0, 1023));
				endcase
			end
			case ($urandom_range(0, 9))
				7: w.resistance = RES_W'($urandom_range(1000, 1001));
				8, 9: w.resistance = RES_W'($urandom_range(0, 65535));
				default: w.resistance = RES_W'($urandom_range(0, 1000));
			endcase
			pending_meas_q.push_back(w);
		end
	endtask

	initial begin
		bit cold;
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		meas.valid  = 1'b0;
		meas.start_req   = 1'b0;
		meas.temperature = '0;
		meas.resistance  = '0;
		drive.ready = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset values of the registers
		@(negedge clk);
		push_meas(1'b1, 0, 0);
		push_meas(1'b0, 1023, 65535);
		push_meas(1'b0, 0, 1001);
		wait_idle();

		// full gains, hot target, start power above the cap
		cfg_write(REG_TARGET_TEMP, 32'd1023);
		cfg_write(REG_GAIN_P, 32'd65535);
		cfg_write(REG_GAIN_I, 32'd65535);
		cfg_write(REG_GAIN_D, 32'd65535);
		cfg_write(REG_INIT_WATTS, 32'd65535);
		@(negedge clk);
		push_meas(1'b1, 0, 0);
		push_meas(1'b0, 0, 1000);
		push_meas(1'b0, 1023, 1001);
		push_meas(1'b0, 512, 65535);
		push_meas(1'b1, 1023, 0);
		push_meas(1'b0, 700, 999);
		wait_idle();

		// cold target drives the power negative; unused addresses are ignored
		cfg_write(REG_TARGET_TEMP, 32'd0);
		cfg_write(REG_GAIN_P, 32'd5000);
		cfg_write(REG_GAIN_I, 32'd300);
		cfg_write(REG_GAIN_D, 32'd65535);
		cfg_write(REG_INIT_WATTS, 32'd0);
		for (int k = REG_INIT_WATTS + 1; k < 8; k++)
			cfg_write(reg_idx_t'(k), $urandom);
		@(negedge clk);
		push_meas(1'b1, 1023, 0);
		push_meas(1'b0, 1023, 0);
		push_meas(1'b0, 0, 0);
		push_meas(1'b0, 1023, 1000);
		wait_idle();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			cold = (ph == 1);
			case (ph)
				0: begin
					cfg_write(REG_TARGET_TEMP, 32'd0);
					cfg_write(REG_GAIN_P, 32'd65535);
					cfg_write(REG_GAIN_I, 32'd65535);
					cfg_write(REG_GAIN_D, 32'd65535);
					cfg_write(REG_INIT_WATTS, 32'd0);
				end
				1: begin
					cfg_write(REG_TARGET_TEMP, 32'd1023);
					cfg_write(REG_GAIN_P, 32'd0);
					cfg_write(REG_GAIN_I, 32'd65535);
					cfg_write(REG_GAIN_D, 32'd0);
					cfg_write(REG_INIT_WATTS, 32'd60000);
				end
				default: begin
					cfg_write(REG_TARGET_TEMP, with_junk($urandom_range(0, 1023), TEMP_W));
					cfg_write(REG_GAIN_P, with_junk(pick_gain(), GAIN_W));
					cfg_write(REG_GAIN_I, with_junk(pick_gain(), GAIN_W));
					cfg_write(REG_GAIN_D, with_junk(pick_gain(), GAIN_W));
					cfg_write(REG_INIT_WATTS, with_junk($urandom_range(0, 65535), 16));
				end
			endcase
			@(negedge clk);
			src_bursty <= (ph == 2) ? 1'b0 : $urandom_range(0, 3) != 0;
			sink_mode  <= (ph == 2) ? 0 : $urandom_range(0, 2);
			// hold the receiver while the sender keeps offering
			if (ph == 2)
				hold_seq <= hold_seq + 1;
			push_ticks(PHASE_ITEMS / 2, 1'b1, cold);
			// pause the sender until every word is back
			wait_idle();
			@(negedge clk);
			push_ticks(PHASE_ITEMS - PHASE_ITEMS / 2, 1'b0, cold);
			wait_idle();
		end

		if (mismatch_count == 0)
			$display("tb_heater_temperature_pid_power_top: done, clean");
		else
			$display("tb_heater_temperature_pid_power_top: done, errors");
		$finish;
	end

	initial begin
		#400000;
		$display("tb_heater_temperature_pid_power_top: done, errors");
		$finish;
	end
endmodule
